[rtl/core/svn_pkg.sv]
package svn_pkg;

	localparam int DEF_VERTEX_COUNT = 1024;
	localparam int DEF_COORD_BITS   = 16;
	localparam int DEF_SUM_BITS     = 40;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FACE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	// Unassigned command code; items that carry it are dropped.
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	// Number of quotient bits produced per normal component.
	localparam int DIV_STEPS = 16;
	// Number of result bits produced by the square root unit.
	localparam int SQRT_STEPS = 32;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PRD,
		OP_PCAP,
		OP_EDGE,
		OP_MUL,
		OP_CROSS,
		OP_SRD,
		OP_SWR,
		OP_RRD,
		OP_RCAP,
		OP_NORM,
		OP_SQ,
		OP_SQRT,
		OP_DIV,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic       take;
		dp_op_t     op;
		logic [1:0] sel;
		logic [4:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_face;
		logic is_read;
		logic vi_ok;
		logic face_ok;
		logic sum_zero;
		logic norm_left;
		logic norm_right;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/smooth_vertex_normals.sv]
// Area-weighted smooth vertex normals, one item at a time. Load: a position write and an
// accumulator clear. Face: three position reads, six products on one multiplier, three
// accumulator read-modify-writes. Read: the normalizing shift, the bit-serial square root
// and three divisions; a zero sum skips them. The result waits in an output register.
// Reset (arst_n low, asynchronous) clears control state only; stores are not swept.
module smooth_vertex_normals import svn_pkg::*; #(
	parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
	parameter int COORD_BITS   = DEF_COORD_BITS,
	parameter int SUM_BITS     = DEF_SUM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         vertex_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               isolated,
	output logic               overflowed
);

	// The controller sequences each item; the datapath holds the position and
	// accumulator memories, the shared multiplier and the iterative root and
	// divider units. A transfer on the input side is taken only when the
	// controller is idle, while a finished result may still wait for its
	// output transfer, so load and face items keep flowing behind it.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	svn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	svn_dp #(
		.VERTEX_COUNT (VERTEX_COUNT),
		.COORD_BITS   (COORD_BITS),
		.SUM_BITS     (SUM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.isolated     (isolated),
		.overflowed   (overflowed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

[rtl/core/svn_ctrl.sv]
module svn_ctrl import svn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_DISP  = 17'b00000000000000010,
		S_LOAD  = 17'b00000000000000100,
		S_PRD   = 17'b00000000000001000,
		S_PCAP  = 17'b00000000000010000,
		S_EDGE  = 17'b00000000000100000,
		S_MUL   = 17'b00000000001000000,
		S_CROSS = 17'b00000000010000000,
		S_SRD   = 17'b00000000100000000,
		S_SWR   = 17'b00000001000000000,
		S_RRD   = 17'b00000010000000000,
		S_RCAP  = 17'b00000100000000000,
		S_NORM  = 17'b00001000000000000,
		S_SQ    = 17'b00010000000000000,
		S_SQRT  = 17'b00100000000000000,
		S_DIV   = 17'b01000000000000000,
		S_OUT   = 17'b10000000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic [4:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cnt_d   = cnt_q;
		cmd.take = in_valid && in_ready;
		cmd.sel  = sel_q;
		cmd.cnt  = cnt_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				sel_d = 2'd0;
				cnt_d = 5'd0;
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				if (stat.is_load && stat.vi_ok) state_d = S_LOAD;
				else if (stat.is_face && stat.face_ok) state_d = S_PRD;
				else if (stat.is_read) state_d = S_RRD;
				else state_d = S_IDLE;
			end
			S_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = S_IDLE;
			end
			S_PRD: begin
				cmd.op  = OP_PRD;
				state_d = S_PCAP;
			end
			S_PCAP: begin
				cmd.op = OP_PCAP;
				if (sel_q == 2'd2) begin
					sel_d   = 2'd0;
					state_d = S_EDGE;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = S_PRD;
				end
			end
			S_EDGE: begin
				cmd.op  = OP_EDGE;
				cnt_d   = 5'd0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				if (cnt_q == 5'd5) begin
					cnt_d   = 5'd0;
					state_d = S_CROSS;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_CROSS: begin
				cmd.op  = OP_CROSS;
				sel_d   = 2'd0;
				state_d = S_SRD;
			end
			S_SRD: begin
				cmd.op  = OP_SRD;
				state_d = S_SWR;
			end
			S_SWR: begin
				cmd.op = OP_SWR;
				if (sel_q == 2'd2) begin
					sel_d   = 2'd0;
					state_d = S_IDLE;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = S_SRD;
				end
			end
			S_RRD: begin
				cmd.op  = OP_RRD;
				state_d = stat.vi_ok ? S_RCAP : S_OUT;
			end
			S_RCAP: begin
				cmd.op  = OP_RCAP;
				state_d = stat.sum_zero ? S_OUT : S_NORM;
			end
			S_NORM: begin
				cmd.op = OP_NORM;
				if (!stat.norm_left && !stat.norm_right) begin
					cnt_d   = 5'd0;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				if (cnt_q == 5'd2) begin
					cnt_d   = 5'd0;
					state_d = S_SQRT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					cnt_d   = 5'd0;
					sel_d   = 2'd0;
					state_d = S_DIV;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == 5'(DIV_STEPS)) begin
					cnt_d = 5'd0;
					if (sel_q == 2'd2) state_d = S_OUT;
					else sel_d = sel_q + 2'd1;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 2'd0;
			cnt_q   <= 5'd0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[rtl/core/svn_dp.sv]
module svn_dp import svn_pkg::*; #(
	parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
	parameter int COORD_BITS   = DEF_COORD_BITS,
	parameter int SUM_BITS     = DEF_SUM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         command,
	input  logic [9:0]         vertex_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               isolated,
	output logic               overflowed,
	output logic               out_valid,
	input  logic               out_ready,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat
);

	localparam int AW  = $clog2(VERTEX_COUNT);
	localparam int EW  = COORD_BITS + 1;
	localparam int PW  = 2 * EW;
	localparam int NW  = PW + 1;
	localparam int ACW = ((SUM_BITS > NW) ? SUM_BITS : NW) + 1;
	localparam int MW  = (SUM_BITS > 32) ? SUM_BITS : 32;
	localparam int PSW = 3 * COORD_BITS;
	localparam int SWW = 3 * SUM_BITS + 1;

	localparam logic signed [ACW-1:0] SUM_HI =
		{{(ACW - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
	localparam logic signed [ACW-1:0] SUM_LO = ~SUM_HI;

	function automatic logic idx_ok(input logic [9:0] i);
		return 32'(i) < VERTEX_COUNT;
	endfunction

	// Latched item.
	logic [1:0]            cmd_q;
	logic [9:0]            vi_q, ca_q, cb_q, cc_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;

	// Stores.
	logic [PSW-1:0] pos_mem [VERTEX_COUNT];
	logic [SWW-1:0] sum_mem [VERTEX_COUNT];
	logic [PSW-1:0] pos_rd_q;
	logic [SWW-1:0] sum_rd_q;

	// Face datapath.
	logic [PSW-1:0]       pv_q   [3];
	logic signed [EW-1:0] e1_q   [3];
	logic signed [EW-1:0] e2_q   [3];
	logic signed [PW-1:0] prod_q [6];
	logic signed [NW-1:0] n_q    [3];

	// Read datapath.
	logic [MW-1:0] m_q  [3];
	logic [2:0]    sgn_q;
	logic          zero_q, ovf_q;
	logic [63:0]   sq_q, rem_q, root_q;
	logic [32:0]   drem_q;
	logic [15:0]   low_q, dq_q;
	logic [15:0]   qv_q [3];

	logic [9:0]         corner;
	logic [AW-1:0]      sum_addr;
	logic [SWW-1:0]     sum_wr;
	logic signed [EW-1:0] op_a, op_b;
	logic               out_free;
	logic               norm_left, norm_right;

	always_comb begin
		unique case (cmd.sel)
			2'd0:    corner = ca_q;
			2'd1:    corner = cb_q;
			default: corner = cc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= command;
			vi_q  <= vertex_index;
			ca_q  <= corner_a;
			cb_q  <= corner_b;
			cc_q  <= corner_c;
			px_q  <= COORD_BITS'(pos_x);
			py_q  <= COORD_BITS'(pos_y);
			pz_q  <= COORD_BITS'(pos_z);
		end
	end

	assign stat.is_load    = (cmd_q == CMD_LOAD);
	assign stat.is_face    = (cmd_q == CMD_FACE);
	assign stat.is_read    = (cmd_q == CMD_READ);
	assign stat.vi_ok      = idx_ok(vi_q);
	assign stat.face_ok    = idx_ok(ca_q) && idx_ok(cb_q) && idx_ok(cc_q);
	assign stat.sum_zero   = (sum_rd_q[3*SUM_BITS-1:0] == '0);
	assign stat.out_free   = out_free;
	assign stat.norm_left  = norm_left;
	assign stat.norm_right = norm_right;

	always_comb begin
		norm_left  = 1'b1;
		norm_right = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (m_q[k][MW-1:30] != '0) norm_left = 1'b0;
			if (m_q[k][MW-1:31] != '0) norm_right = 1'b1;
		end
	end

	// Position store.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) pos_mem[AW'(vi_q)] <= {pz_q, py_q, px_q};
		pos_rd_q <= pos_mem[AW'(corner)];
	end

	// Accumulator store.
	assign sum_addr = (cmd.op == OP_SRD || cmd.op == OP_SWR) ? AW'(corner) : AW'(vi_q);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) sum_mem[sum_addr] <= '0;
		else if (cmd.op == OP_SWR) sum_mem[sum_addr] <= sum_wr;
		sum_rd_q <= sum_mem[sum_addr];
	end

	// Saturating accumulation of the face normal.
	always_comb begin
		logic signed [SUM_BITS-1:0] acc;
		logic signed [ACW-1:0]      wide;
		sum_wr = '0;
		sum_wr[3*SUM_BITS] = sum_rd_q[3*SUM_BITS];
		for (int k = 0; k < 3; k++) begin
			acc  = $signed(sum_rd_q[k*SUM_BITS +: SUM_BITS]);
			wide = ACW'(acc) + ACW'(n_q[k]);
			if (wide > SUM_HI) begin
				sum_wr[k*SUM_BITS +: SUM_BITS] = SUM_BITS'(SUM_HI);
				sum_wr[3*SUM_BITS] = 1'b1;
			end else if (wide < SUM_LO) begin
				sum_wr[k*SUM_BITS +: SUM_BITS] = SUM_BITS'(SUM_LO);
				sum_wr[3*SUM_BITS] = 1'b1;
			end else begin
				sum_wr[k*SUM_BITS +: SUM_BITS] = SUM_BITS'(wide);
			end
		end
	end

	// Shared multiplier operands for the six cross product terms.
	always_comb begin
		unique case (cmd.cnt[2:0])
			3'd0:    begin op_a = e1_q[1]; op_b = e2_q[2]; end
			3'd1:    begin op_a = e1_q[2]; op_b = e2_q[1]; end
			3'd2:    begin op_a = e1_q[2]; op_b = e2_q[0]; end
			3'd3:    begin op_a = e1_q[0]; op_b = e2_q[2]; end
			3'd4:    begin op_a = e1_q[0]; op_b = e2_q[1]; end
			default: begin op_a = e1_q[1]; op_b = e2_q[0]; end
		endcase
	end

	always_ff @(posedge clk) begin
		logic signed [COORD_BITS-1:0] ca, cb, cc;
		if (cmd.op == OP_PCAP) pv_q[cmd.sel] <= pos_rd_q;
		if (cmd.op == OP_EDGE) begin
			for (int k = 0; k < 3; k++) begin
				ca = $signed(pv_q[0][k*COORD_BITS +: COORD_BITS]);
				cb = $signed(pv_q[1][k*COORD_BITS +: COORD_BITS]);
				cc = $signed(pv_q[2][k*COORD_BITS +: COORD_BITS]);
				e1_q[k] <= EW'(cb) - EW'(ca);
				e2_q[k] <= EW'(cc) - EW'(ca);
			end
		end
		if (cmd.op == OP_MUL) prod_q[cmd.cnt[2:0]] <= PW'(op_a) * PW'(op_b);
		if (cmd.op == OP_CROSS) begin
			for (int k = 0; k < 3; k++)
				n_q[k] <= NW'(prod_q[2*k]) - NW'(prod_q[2*k+1]);
		end
	end

	// Magnitudes, normalizing shift, squares, root and divisions.
	always_ff @(posedge clk) begin
		logic signed [SUM_BITS-1:0] s;
		logic [SUM_BITS-1:0]        mag;
		logic [61:0]                sqr;
		logic [63:0]                bitv, nsrc, rsrc;
		logic [45:0]                num;
		logic [32:0]                trial;
		logic                       qbit;
		if (cmd.op == OP_RRD && !stat.vi_ok) begin
			zero_q <= 1'b1;
			ovf_q  <= 1'b0;
		end
		if (cmd.op == OP_RCAP) begin
			zero_q <= stat.sum_zero;
			ovf_q  <= sum_rd_q[3*SUM_BITS];
			for (int k = 0; k < 3; k++) begin
				s   = $signed(sum_rd_q[k*SUM_BITS +: SUM_BITS]);
				mag = (s < 0) ? SUM_BITS'(-s) : SUM_BITS'(s);
				m_q[k]   <= MW'(mag);
				sgn_q[k] <= s[SUM_BITS-1];
			end
		end
		if (cmd.op == OP_NORM) begin
			for (int k = 0; k < 3; k++) begin
				if (stat.norm_right) m_q[k] <= m_q[k] >> 1;
				else if (stat.norm_left) m_q[k] <= m_q[k] << 1;
			end
		end
		if (cmd.op == OP_SQ) begin
			sqr  = m_q[cmd.cnt[1:0]][30:0] * m_q[cmd.cnt[1:0]][30:0];
			sq_q <= ((cmd.cnt == 5'd0) ? 64'd0 : sq_q) + 64'(sqr);
		end
		if (cmd.op == OP_SQRT) begin
			bitv = 64'd1 << (6'd62 - {cmd.cnt, 1'b0});
			nsrc = (cmd.cnt == 5'd0) ? sq_q : rem_q;
			rsrc = (cmd.cnt == 5'd0) ? 64'd0 : root_q;
			if (nsrc >= rsrc + bitv) begin
				rem_q  <= nsrc - (rsrc + bitv);
				root_q <= (rsrc >> 1) + bitv;
			end else begin
				rem_q  <= nsrc;
				root_q <= rsrc >> 1;
			end
		end
		if (cmd.op == OP_DIV) begin
			if (cmd.cnt == 5'd0) begin
				num    = 46'({m_q[cmd.sel][30:0], 14'd0}) + 46'(root_q[31:1]);
				drem_q <= 33'(num[45:16]);
				low_q  <= num[15:0];
				dq_q   <= 16'd0;
			end else begin
				trial = {drem_q[31:0], low_q[15]};
				qbit  = (trial >= {1'b0, root_q[31:0]});
				drem_q <= qbit ? trial - {1'b0, root_q[31:0]} : trial;
				low_q  <= low_q << 1;
				dq_q   <= {dq_q[14:0], qbit};
				if (cmd.cnt == 5'(DIV_STEPS)) qv_q[cmd.sel] <= {dq_q[14:0], qbit};
			end
		end
	end

	// Output register.
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == OP_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT && out_free) begin
			isolated   <= zero_q;
			overflowed <= ovf_q;
			if (zero_q) begin
				normal_x <= 16'sd0;
				normal_y <= 16'sd0;
				normal_z <= ONE_Q14;
			end else begin
				normal_x <= sgn_q[0] ? -$signed(qv_q[0]) : $signed(qv_q[0]);
				normal_y <= sgn_q[1] ? -$signed(qv_q[1]) : $signed(qv_q[1]);
				normal_z <= sgn_q[2] ? -$signed(qv_q[2]) : $signed(qv_q[2]);
			end
		end
	end

endmodule

[tb/sv/smooth_vertex_normals_checker.sv]
`timescale 1ns / 100ps

module smooth_vertex_normals_checker import svn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         vertex_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               isolated,
	input  logic               overflowed,
	output int                 failures,
	output int                 pending
);

	localparam int NV = DEF_VERTEX_COUNT;
	localparam longint SUM_HI = (64'sd1 <<< (DEF_SUM_BITS - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               iso;
		logic               ovf;
	} vertex_normal_t;

	longint px [NV];
	longint py [NV];
	longint pz [NV];
	longint acc_x [NV];
	longint acc_y [NV];
	longint acc_z [NV];
	bit     acc_sat [NV];

	vertex_normal_t normal_queue[$];

	int fail_count = 0;

	assign pending  = normal_queue.size();
	assign failures = fail_count;

	function automatic longint clamp_add(longint acc, longint add, inout bit sat);
		if (add > 0 && acc > SUM_HI - add) begin
			sat = 1'b1;
			return SUM_HI;
		end
		if (add < 0 && acc < SUM_LO - add) begin
			sat = 1'b1;
			return SUM_LO;
		end
		return acc + add;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic add_face_normal(int v, longint fx, longint fy, longint fz);
		bit s;
		s = acc_sat[v];
		acc_x[v] = clamp_add(acc_x[v], fx, s);
		acc_y[v] = clamp_add(acc_y[v], fy, s);
		acc_z[v] = clamp_add(acc_z[v], fz, s);
		acc_sat[v] = s;
	endtask

	// Unit normal of one vertex, scaled so the largest magnitude sits in
	// [2^30, 2^31) before the square root.
	function automatic vertex_normal_t unit_normal(int v);
		vertex_normal_t r;
		longint s [3];
		longint unsigned m [3];
		longint unsigned top, len, sq, q;
		int p;
		s[0] = acc_x[v];
		s[1] = acc_y[v];
		s[2] = acc_z[v];
		r.ovf = acc_sat[v];
		if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
			r.nx = '0;
			r.ny = '0;
			r.nz = ONE_Q14;
			r.iso = 1'b1;
			return r;
		end
		for (int k = 0; k < 3; k++)
			m[k] = (s[k] < 0) ? longint'(-s[k]) : longint'(s[k]);
		top = m[0];
		if (m[1] > top) top = m[1];
		if (m[2] > top) top = m[2];
		p = 0;
		for (int k = 0; k < 64; k++)
			if (top[k]) p = k;
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			if (p > 30) m[k] = m[k] >> (p - 30);
			else m[k] = m[k] << (30 - p);
			sq = sq + m[k] * m[k];
		end
		len = int_sqrt(sq);
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * 16384 + len / 2) / len;
			if (s[k] < 0) q = -q;
			if (k == 0) r.nx = q[15:0];
			else if (k == 1) r.ny = q[15:0];
			else r.nz = q[15:0];
		end
		r.iso = 1'b0;
		return r;
	endfunction

	task automatic take_item();
		longint e1 [3];
		longint e2 [3];
		int a, b, c;
		a = int'(corner_a);
		b = int'(corner_b);
		c = int'(corner_c);
		case (command)
			CMD_LOAD: begin
				px[vertex_index] = longint'(pos_x);
				py[vertex_index] = longint'(pos_y);
				pz[vertex_index] = longint'(pos_z);
				acc_x[vertex_index] = 0;
				acc_y[vertex_index] = 0;
				acc_z[vertex_index] = 0;
				acc_sat[vertex_index] = 1'b0;
			end
			CMD_FACE: begin
				e1[0] = px[b] - px[a];
				e1[1] = py[b] - py[a];
				e1[2] = pz[b] - pz[a];
				e2[0] = px[c] - px[a];
				e2[1] = py[c] - py[a];
				e2[2] = pz[c] - pz[a];
				// Corners are updated in order a, b, c so a repeated corner
				// collects the product more than once.
				for (int k = 0; k < 3; k++)
					add_face_normal(k == 0 ? a : (k == 1 ? b : c),
						e1[1] * e2[2] - e1[2] * e2[1],
						e1[2] * e2[0] - e1[0] * e2[2],
						e1[0] * e2[1] - e1[1] * e2[0]);
			end
			CMD_READ: normal_queue.insert(normal_queue.size(),
				unit_normal(int'(vertex_index)));
			default: ;
		endcase
	endtask

	task automatic check_result();
		vertex_normal_t e;
		if (normal_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result transfer with nothing expected", $realtime);
			return;
		end
		e = normal_queue.pop_front();
		if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
				isolated !== e.iso || overflowed !== e.ovf) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: mismatch: expected (%0d %0d %0d %0b %0b) got (%0d %0d %0d %0b %0b)",
					$realtime, e.nx, e.ny, e.nz, e.iso, e.ovf,
					normal_x, normal_y, normal_z, isolated, overflowed);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				take_item();
			if (out_valid && out_ready)
				check_result();
		end
	end

endmodule

[tb/sv/smooth_vertex_normals_tb.sv]
`timescale 1ns / 100ps

module smooth_vertex_normals_tb;
	import svn_pkg::*;

	// The run is ended as a failure once the total cycle count passes this limit.
	localparam int CYCLE_LIMIT = 3000000;
	// Number of cycles the receiver refuses results during the long hold-off.
	localparam int HOLD_CYCLES = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = CMD_LOAD;
	logic [9:0]         vertex_index = '0;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic signed [15:0] pos_z = '0;
	logic [9:0]         corner_a = '0;
	logic [9:0]         corner_b = '0;
	logic [9:0]         corner_c = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               isolated;
	logic               overflowed;

	int failures;
	int pending;

	// Idle percentages for each side; changed between phases.
	int send_idle = 10;
	int recv_idle = 77;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	// Vertices that have been loaded. Faces and reads only name these,
	// since the stores hold nothing meaningful before a load.
	bit loaded [1024];
	int vertex_pool[$];

	always #5 clk = ~clk;

	smooth_vertex_normals dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .vertex_index(vertex_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.isolated(isolated), .overflowed(overflowed)
	);

	smooth_vertex_normals_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .vertex_index(vertex_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.isolated(isolated), .overflowed(overflowed),
		.failures(failures), .pending(pending)
	);

	// Watchdog: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** smooth_vertex_normals: FAILED **");
			$finish;
		end
	end

	// Receiver. It normally stalls at random, and once, when asked, holds
	// off for a long stretch so the output register fills and the block
	// backs up into its input channel.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offers one item and waits for its transfer. Idle cycles are inserted
	// before the item, so gaps land on whatever the block is doing.
	task automatic send_item(input logic [1:0] cmd, input logic [9:0] vi,
			input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z, input logic [9:0] a,
			input logic [9:0] b, input logic [9:0] c);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		vertex_index <= vi;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		corner_a <= a;
		corner_b <= b;
		corner_c <= c;
		if (cmd == CMD_LOAD && !loaded[vi]) begin
			loaded[vi] = 1'b1;
			vertex_pool.insert(vertex_pool.size(), int'(vi));
		end
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic signed [15:0] random_coord();
		case ($urandom_range(3))
			0: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
			1: return 16'($urandom_range(511) - 256);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [9:0] pool_vertex();
		return 10'(vertex_pool[$urandom_range(vertex_pool.size() - 1)]);
	endfunction

	task automatic load_vertex(input logic [9:0] vi, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		send_item(CMD_LOAD, vi, x, y, z, 10'($urandom()), 10'($urandom()), 10'($urandom()));
	endtask

	task automatic face_item(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c);
		send_item(CMD_FACE, 10'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()), a, b, c);
	endtask

	task automatic read_item(input logic [9:0] vi);
		send_item(CMD_READ, vi, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			10'($urandom()), 10'($urandom()), 10'($urandom()));
	endtask

	// One random item. Indices for loads span the whole range so every
	// index bit toggles; faces and reads stay within loaded vertices, and a
	// small pool keeps the accumulators busy.
	task automatic random_item();
		int pick;
		int near;
		pick = $urandom_range(99);
		near = (vertex_pool.size() < 8) ? vertex_pool.size() - 1 : 7;
		if (vertex_pool.size() < 3 || pick < 15) begin
			if (vertex_pool.size() >= 24 && $urandom_range(3) != 0)
				load_vertex(pool_vertex(), random_coord(), random_coord(), random_coord());
			else
				load_vertex(10'($urandom()), random_coord(), random_coord(),
					random_coord());
		end else if (pick < 68) begin
			if ($urandom_range(9) == 0)
				face_item(pool_vertex(), pool_vertex(), pool_vertex());
			else
				face_item(10'(vertex_pool[$urandom_range(near)]), pool_vertex(),
					pool_vertex());
		end else if (pick < 95) begin
			read_item(pool_vertex());
		end else begin
			send_item(CMD_NONE, 10'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()));
		end
	endtask

	// A burst of faces on one large triangle drives its corners'
	// accumulators into saturation, then reads show the sticky flag.
	task automatic saturate_burst();
		logic [9:0] a, b, c;
		a = 10'($urandom());
		b = a + 10'd1;
		c = a + 10'd2;
		load_vertex(a, 16'sh8000, 16'sh8000, 16'sh8000);
		load_vertex(b, 16'sh7fff, 16'sh8000, 16'sh7fff);
		load_vertex(c, 16'sh8000, 16'sh7fff, 16'sh7fff);
		repeat (140) face_item(a, b, c);
		read_item(a);
		read_item(b);
		read_item(c);
	endtask

	// Waits until the checker has booked the last transfer and no results are pending.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme positions at the extreme indices, a read of
		// a vertex with a zero sum, a real face and its mirror, repeated
		// corners that give a zero product, and an unknown command.
		load_vertex(10'd0, 16'sh8000, 16'sh8000, 16'sh0000);
		load_vertex(10'd1023, 16'sh7fff, 16'sh8000, 16'sh7fff);
		load_vertex(10'd512, 16'sh8000, 16'sh7fff, 16'sh8000);
		read_item(10'd0);
		face_item(10'd0, 10'd1023, 10'd512);
		read_item(10'd0);
		read_item(10'd1023);
		read_item(10'd512);
		face_item(10'd0, 10'd0, 10'd0);
		face_item(10'd0, 10'd1023, 10'd1023);
		read_item(10'd1023);
		face_item(10'd512, 10'd0, 10'd1023);
		face_item(10'd0, 10'd512, 10'd1023);
		read_item(10'd0);
		send_item(CMD_NONE, 10'h3ff, 16'sh7fff, 16'sh8000, 16'shffff,
			10'h3ff, 10'h3ff, 10'h3ff);
		load_vertex(10'd341, 16'sh0000, 16'sh0000, 16'sh0000);
		load_vertex(10'd682, 16'shffff, 16'sh0001, 16'sh5555);
		load_vertex(10'd170, 16'shaaaa, 16'sh0100, 16'sh7fff);
		face_item(10'd341, 10'd682, 10'd170);
		read_item(10'd341);
		read_item(10'd170);
		load_vertex(10'd512, 16'sh0000, 16'sh0000, 16'sh0000);
		read_item(10'd512);
		in_valid <= 1'b0;
		wait_drained();

		// Phase with a mostly idle receiver, including the long hold-off.
		for (int i = 0; i < 700; i++) begin
			if (i == 100)
				hold_req = 1'b1;
			random_item();
		end
		saturate_burst();
		in_valid <= 1'b0;
		wait_drained();

		send_idle = 77;
		recv_idle = 10;
		for (int i = 0; i < 700; i++)
			random_item();
		in_valid <= 1'b0;
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 450; i++)
			random_item();
		saturate_burst();
		in_valid <= 1'b0;

		wait_drained();
		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("** smooth_vertex_normals: PASSED **");
		end else begin
			$display("** smooth_vertex_normals: FAILED **");
		end
		$finish;
	end

endmodule
